>>> design/x64er_pkg.sv
// shared types and constants for the x86-64 epilog recogniser
package x64er_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_OPC   = 3'd1,
    PH_MODRM = 3'd2,
    PH_SKIP  = 3'd3,
    PH_POP   = 3'd4,
    PH_REXED = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    V_NO     = 2'd0,
    V_YES    = 2'd1,
    V_UNREAD = 2'd2
  } verdict_e;

  localparam logic [7:0] RexMask   = 8'hf8;
  localparam logic [7:0] RexW      = 8'h48;
  localparam logic [7:0] OpAddImm  = 8'h81;
  localparam logic [7:0] OpAddImm8 = 8'h83;
  localparam logic [7:0] OpLea     = 8'h8d;
  localparam logic [7:0] ModrmRsp  = 8'hc4;
  localparam logic [7:0] RexRxMask = 8'h06;
  localparam logic [7:0] AnyRexMsk = 8'hf0;
  localparam logic [7:0] AnyRex    = 8'h40;
  localparam logic [7:0] PopBase   = 8'h58;
  localparam logic [7:0] RetImm    = 8'hc2;
  localparam logic [7:0] RetNear   = 8'hc3;

  localparam logic [2:0] RegRsp    = 3'd4;
  localparam logic [2:0] RmSib     = 3'd4;
  localparam logic [1:0] ModDisp8  = 2'd1;
  localparam logic [1:0] ModDisp32 = 2'd2;

  localparam logic [2:0] SkipImm8  = 3'd1;
  localparam logic [2:0] SkipImm32 = 3'd4;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       scan_start;
    logic       byte_readable;
  } item_t;

  typedef struct packed {
    logic     valid;
    verdict_e verdict;
  } result_t;

endpackage

>>> design/x64_epilog_recognizer.sv
// top level: input register, scan decode and verdict output register
// Takes one code byte per beat and answers with one verdict per scan; a byte
// passes the input register, is decoded combinationally against the scan state
// and its verdict, if any, lands in the output register, so a beat can be taken
// every cycle unless the output register holds a verdict not yet taken.
// Throughput is one byte per cycle, set by the scan state update;
// it drops only while the output register holds a verdict not yet taken.
module x64_epilog_recognizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] code_byte
  input  logic [1:0] s_axis_tuser_i,   // [0] scan_start, [1] byte_readable
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [1:0] verdict, [7:2] zero
);

  logic                in_valid_q, in_valid_d;
  x64er_pkg::item_t    in_q, in_d;
  logic                out_valid_q, out_valid_d;
  x64er_pkg::verdict_e out_verdict_q, out_verdict_d;
  logic                adv, step;
  x64er_pkg::result_t  res;

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && adv;
  assign s_axis_tready_o = !in_valid_q || adv;

  x64er_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .res_o  (res)
  );

  always_comb begin
    in_valid_d    = in_valid_q;
    in_d          = in_q;
    out_valid_d   = out_valid_q;
    out_verdict_d = out_verdict_q;
    if (s_axis_tready_o) begin
      in_valid_d       = s_axis_tvalid_i;
      in_d.code_byte     = s_axis_tdata_i;
      in_d.scan_start    = s_axis_tuser_i[0];
      in_d.byte_readable = s_axis_tuser_i[1];
    end
    if (adv) begin
      out_valid_d   = step && res.valid;
      out_verdict_d = res.verdict;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q          <= in_d;
    out_verdict_q <= out_verdict_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_verdict_q};

  a_verdict_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[1:0] <= x64er_pkg::V_UNREAD)
    else $error("verdict code out of range");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && out_valid_q && !m_axis_tready_i)
    else $error("input stalled with room in the pipeline");

  a_unread_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_q.scan_start && !in_q.byte_readable |=>
      m_axis_tvalid_o && m_axis_tdata_o[1:0] == x64er_pkg::V_UNREAD)
    else $error("unreadable first beat gave no unreadable verdict");

endmodule

>>> design/x64er_scan.sv
// scan state register and per-beat epilog decode
module x64er_scan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  x64er_pkg::item_t item_i,
  output x64er_pkg::result_t res_o
);

  x64er_pkg::phase_e phase_q, phase_d;
  logic [7:0] first_prefix_q, first_prefix_d;
  logic [7:0] second_opcode_q, second_opcode_d;
  logic [2:0] skip_left_q, skip_left_d;

  logic [7:0] b;
  logic       is_rexw_any, is_rex, is_pop, is_ret;
  logic       fin;
  x64er_pkg::verdict_e verd;

  assign b           = item_i.code_byte;
  assign is_rexw_any = (b & x64er_pkg::RexMask) == x64er_pkg::RexW;
  assign is_rex      = (b & x64er_pkg::AnyRexMsk) == x64er_pkg::AnyRex;
  assign is_pop      = (b & x64er_pkg::RexMask) == x64er_pkg::PopBase;
  assign is_ret      = (b == x64er_pkg::RetImm) || (b == x64er_pkg::RetNear);

  always_comb begin
    phase_d         = phase_q;
    first_prefix_d  = first_prefix_q;
    second_opcode_d = second_opcode_q;
    skip_left_d     = skip_left_q;
    fin             = 1'b0;
    verd            = x64er_pkg::V_NO;
    if (step_i) begin
      if (item_i.scan_start) begin
        phase_d     = x64er_pkg::PH_IDLE;
        skip_left_d = '0;
        if (!item_i.byte_readable) begin
          fin  = 1'b1;
          verd = x64er_pkg::V_UNREAD;
        end else if (is_rexw_any) begin
          first_prefix_d = b;
          phase_d        = x64er_pkg::PH_OPC;
        end else if (is_rex) begin
          phase_d = x64er_pkg::PH_REXED;
        end else if (is_pop) begin
          phase_d = x64er_pkg::PH_POP;
        end else begin
          fin  = 1'b1;
          verd = is_ret ? x64er_pkg::V_YES : x64er_pkg::V_NO;
        end
      end else begin
        case (phase_q)
          x64er_pkg::PH_IDLE: begin
            phase_d = x64er_pkg::PH_IDLE;
          end
          x64er_pkg::PH_SKIP: begin
            if (skip_left_q > 3'd1) begin
              skip_left_d = skip_left_q - 3'd1;
            end else begin
              skip_left_d = '0;
              phase_d     = x64er_pkg::PH_POP;
            end
          end
          x64er_pkg::PH_OPC, x64er_pkg::PH_MODRM,
          x64er_pkg::PH_POP, x64er_pkg::PH_REXED: begin
            if (!item_i.byte_readable) begin
              fin  = 1'b1;
              verd = x64er_pkg::V_UNREAD;
            end else if (phase_q == x64er_pkg::PH_OPC &&
                         (b == x64er_pkg::OpAddImm || b == x64er_pkg::OpAddImm8 ||
                          b == x64er_pkg::OpLea)) begin
              second_opcode_d = b;
              phase_d         = x64er_pkg::PH_MODRM;
            end else if (phase_q == x64er_pkg::PH_MODRM) begin
              if (second_opcode_q == x64er_pkg::OpAddImm ||
                  second_opcode_q == x64er_pkg::OpAddImm8) begin
                if (first_prefix_q != x64er_pkg::RexW || b != x64er_pkg::ModrmRsp) begin
                  fin = 1'b1;
                end else begin
                  skip_left_d = (second_opcode_q == x64er_pkg::OpAddImm) ?
                                x64er_pkg::SkipImm32 : x64er_pkg::SkipImm8;
                  phase_d     = x64er_pkg::PH_SKIP;
                end
              end else if ((first_prefix_q & x64er_pkg::RexRxMask) != 8'h00 ||
                           b[5:3] != x64er_pkg::RegRsp || b[2:0] == x64er_pkg::RmSib) begin
                fin = 1'b1;
              end else if (b[7:6] == x64er_pkg::ModDisp8) begin
                skip_left_d = x64er_pkg::SkipImm8;
                phase_d     = x64er_pkg::PH_SKIP;
              end else if (b[7:6] == x64er_pkg::ModDisp32) begin
                skip_left_d = x64er_pkg::SkipImm32;
                phase_d     = x64er_pkg::PH_SKIP;
              end else begin
                fin = 1'b1;
              end
            end else if (phase_q == x64er_pkg::PH_POP && is_rex) begin
              phase_d = x64er_pkg::PH_REXED;
            end else if (is_pop) begin
              phase_d = x64er_pkg::PH_POP;
            end else begin
              fin  = 1'b1;
              verd = is_ret ? x64er_pkg::V_YES : x64er_pkg::V_NO;
            end
          end
          default: begin
            phase_d = x64er_pkg::PH_IDLE;
          end
        endcase
      end
      if (fin) begin
        phase_d     = x64er_pkg::PH_IDLE;
        skip_left_d = '0;
      end
    end
  end

  assign res_o.valid   = fin;
  assign res_o.verdict = verd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= x64er_pkg::PH_IDLE;
      first_prefix_q  <= '0;
      second_opcode_q <= '0;
      skip_left_q     <= '0;
    end else begin
      phase_q         <= phase_d;
      first_prefix_q  <= first_prefix_d;
      second_opcode_q <= second_opcode_d;
      skip_left_q     <= skip_left_d;
    end
  end

endmodule
